// ===== design/mhsi_pkg.sv =====
// ----------------------------------------------------------------------------
// mhsi_pkg: shared types and constants for the magnetometer calibration block
// Payload structs, register index codes, datapath widths and the CORDIC
// arctangent table in binary angle units (2^32 per turn).
// ----------------------------------------------------------------------------
package mhsi_pkg;

    // Sample and coefficient field width (fixed by the payload format)
    localparam int S_W    = 16;
    localparam int CFG_W  = 48;
    localparam int IDX_W  = 3;
    // raw - offset
    localparam int D_W    = S_W + 1;
    // coefficient * difference
    localparam int P_W    = S_W + D_W;
    // sum of three products
    localparam int SUM_W  = P_W + 2;
    // CORDIC datapath: room for the gain of about 1.65 and the sqrt(2) of the vector
    localparam int CW     = SUM_W + 2;
    localparam int ANG_W  = 32;
    localparam int TAB_LEN = 24;
    localparam logic [ANG_W-1:0] ANG_HALF = 32'h8000_0000;
    localparam int CD_TURN = 36000;
    localparam int CD_W    = 17;

    // Register index codes
    localparam logic [IDX_W-1:0] CFG_OFFSET = 3'd0;
    localparam logic [IDX_W-1:0] CFG_ROW_X  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_ROW_Y  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_ROW_Z  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_DECL   = 3'd4;

    // atan(2^-i) as a fraction of one turn times 2^32
    localparam logic [ANG_W-1:0] ATAN_TAB [0:TAB_LEN-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic signed [S_W-1:0] raw_x;
        logic signed [S_W-1:0] raw_y;
        logic signed [S_W-1:0] raw_z;
    } t_in;

    typedef struct packed {
        logic signed [S_W-1:0] cal_x;
        logic signed [S_W-1:0] cal_y;
        logic signed [S_W-1:0] cal_z;
        logic [S_W-1:0]        heading_cd;
        logic                  clipped;
    } t_out;

    // Calibrated vector traveling beside the heading path
    typedef struct packed {
        logic signed [S_W-1:0] cal_x;
        logic signed [S_W-1:0] cal_y;
        logic signed [S_W-1:0] cal_z;
        logic                  clipped;
    } t_cal;

endpackage

// ===== design/mag_hard_soft_iron_heading.sv =====
// ----------------------------------------------------------------------------
// mag_hard_soft_iron_heading: magnetometer calibration and heading
// Subtracts hard-iron offsets, applies the soft-iron matrix, saturates the
// calibrated vector and computes a declination-corrected flat-earth heading.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                     Payload
//   input     in         i_in_valid / o_in_ready       i_in_data  (t_in)
//   output    out        o_out_valid / i_out_ready     o_out_data (t_out)
//   config    in         i_cfg_we (no wait)            i_cfg_idx, i_cfg_wdata
//
// One item enters per cycle while the pipeline has room; the pipeline is
// the one-stage-per-iteration CORDIC plus four matrix stages, one fold
// stage and two angle conversion stages. Every stage holds its own valid
// bit and moves when it is empty or its successor moves, so a stalled
// output fills the bubbles first and input stays open until the pipeline
// is full. Reset clears the valid bits and loads the register defaults
// (identity matrix, zero offsets, declination 4.22 degrees); no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module mag_hard_soft_iron_heading
    import mhsi_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 14,
    parameter int CORDIC_STEPS   = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in              i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out             o_out_data,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    // Configuration registers
    logic [CFG_W-1:0] r_offset;
    logic [CFG_W-1:0] r_row [0:2];
    logic [S_W-1:0]   r_decl;

    // Matrix to CORDIC
    logic                    w_mx_valid, w_mx_ready;
    t_cal                    w_mx_cal;
    logic signed [SUM_W-1:0] w_sum_x, w_sum_y;

    // CORDIC to angle conversion
    logic             w_cr_valid, w_cr_ready;
    logic [ANG_W-1:0] w_angle;
    t_cal             w_cr_cal;

    // Take register writes; ignore unused indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_row[0] <= CFG_W'(1) << COEF_FRAC_BITS;
            r_row[1] <= CFG_W'(1) << (COEF_FRAC_BITS + S_W);
            r_row[2] <= CFG_W'(1) << (COEF_FRAC_BITS + 2 * S_W);
            r_decl   <= S_W'(422);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OFFSET: r_offset <= i_cfg_wdata;
                CFG_ROW_X:  r_row[0] <= i_cfg_wdata;
                CFG_ROW_Y:  r_row[1] <= i_cfg_wdata;
                CFG_ROW_Z:  r_row[2] <= i_cfg_wdata;
                CFG_DECL:   r_decl   <= i_cfg_wdata[S_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Offset subtract, matrix multiply, round and saturate
    mhsi_matrix #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_matrix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_data   (i_in_data),
        .i_offset (r_offset),
        .i_row    (r_row),
        .o_valid  (w_mx_valid),
        .i_ready  (w_mx_ready),
        .o_cal    (w_mx_cal),
        .o_sum_x  (w_sum_x),
        .o_sum_y  (w_sum_y)
    );

    // atan2(x, y) on the unrounded row sums; the calibrated vector rides along
    mhsi_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mx_valid),
        .o_ready (w_mx_ready),
        .i_im    (w_sum_x),
        .i_re    (w_sum_y),
        .i_side  (w_mx_cal),
        .o_valid (w_cr_valid),
        .i_ready (w_cr_ready),
        .o_angle (w_angle),
        .o_side  (w_cr_cal)
    );

    // Negate, convert to centidegrees, add declination and wrap
    mhsi_angle u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cr_valid),
        .o_ready (w_cr_ready),
        .i_angle (w_angle),
        .i_side  (w_cr_cal),
        .i_decl  (r_decl),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

// ===== design/mhsi_matrix.sv =====
// ----------------------------------------------------------------------------
// mhsi_matrix: hard-iron subtract and soft-iron matrix multiply
// Four stages: difference, nine products, row sums, round and saturate.
// Row sums of x and y leave unrounded for the heading path.
// ----------------------------------------------------------------------------
module mhsi_matrix
    import mhsi_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  t_in                     i_data,
    input  logic [CFG_W-1:0]        i_offset,
    input  logic [CFG_W-1:0]        i_row [0:2],
    output logic                    o_valid,
    input  logic                    i_ready,
    output t_cal                    o_cal,
    output logic signed [SUM_W-1:0] o_sum_x,
    output logic signed [SUM_W-1:0] o_sum_y
);

    localparam int RW = SUM_W + 1;

    logic r_v1, r_v2, r_v3, r_v4;
    logic w_en1, w_en2, w_en3, w_en4;

    logic signed [D_W-1:0]   r_d [0:2];
    logic signed [D_W-1:0]   n_d [0:2];
    logic signed [P_W-1:0]   r_p [0:8];
    logic signed [P_W-1:0]   n_p [0:8];
    logic signed [SUM_W-1:0] r_sum [0:2];
    logic signed [SUM_W-1:0] n_sum [0:2];
    logic signed [S_W-1:0]   n_cal [0:2];
    logic [2:0]              n_clip;
    logic signed [RW-1:0]    w_rnd [0:2];
    logic signed [RW-1:0]    w_q [0:2];
    logic signed [SUM_W-1:0] r_sx, r_sy;
    t_cal                    r_cal;

    // Each stage moves when it is empty or the next one moves
    assign w_en4   = !r_v4 || i_ready;
    assign w_en3   = !r_v3 || w_en4;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;

    always_comb begin
        n_d[0] = D_W'(i_data.raw_x) - D_W'($signed(i_offset[S_W-1:0]));
        n_d[1] = D_W'(i_data.raw_y) - D_W'($signed(i_offset[2*S_W-1:S_W]));
        n_d[2] = D_W'(i_data.raw_z) - D_W'($signed(i_offset[3*S_W-1:2*S_W]));
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_p[3*r+c] = $signed(i_row[r][c*S_W +: S_W]) * r_d[c];
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_sum[r] = SUM_W'(r_p[3*r]) + SUM_W'(r_p[3*r+1]) + SUM_W'(r_p[3*r+2]);
        end
    end

    // Round half up, then clamp when the upper bits disagree with the sign
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_rnd[r] = RW'(r_sum[r]) + RW'(1 <<< (COEF_FRAC_BITS - 1));
            w_q[r]   = w_rnd[r] >>> COEF_FRAC_BITS;
            if (w_q[r][RW-1:S_W-1] == '0 || w_q[r][RW-1:S_W-1] == '1) begin
                n_cal[r]  = w_q[r][S_W-1:0];
                n_clip[r] = 1'b0;
            end else begin
                n_cal[r]  = {w_q[r][RW-1], {(S_W-1){~w_q[r][RW-1]}}};
                n_clip[r] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) r_d <= n_d;
        if (w_en2) r_p <= n_p;
        if (w_en3) r_sum <= n_sum;
        if (w_en4) begin
            r_cal.cal_x   <= n_cal[0];
            r_cal.cal_y   <= n_cal[1];
            r_cal.cal_z   <= n_cal[2];
            r_cal.clipped <= |n_clip;
            r_sx          <= r_sum[0];
            r_sy          <= r_sum[1];
        end
    end

    assign o_valid = r_v4;
    assign o_cal   = r_cal;
    assign o_sum_x = r_sx;
    assign o_sum_y = r_sy;

endmodule

// ===== design/mhsi_cordic.sv =====
// ----------------------------------------------------------------------------
// mhsi_cordic: vectoring CORDIC, one register stage per iteration
// A fold stage maps the vector to the right half plane; each step then
// rotates toward the real axis and accumulates the binary angle.
// ----------------------------------------------------------------------------
module mhsi_cordic
    import mhsi_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [SUM_W-1:0] i_im,
    input  logic signed [SUM_W-1:0] i_re,
    input  t_cal                    i_side,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [ANG_W-1:0]        o_angle,
    output t_cal                    o_side
);

    localparam int N = CORDIC_STEPS;

    logic                 r_v    [0:N];
    logic                 w_en   [0:N];
    logic signed [CW-1:0] r_re   [0:N];
    logic signed [CW-1:0] r_im   [0:N];
    logic [ANG_W-1:0]     r_z    [0:N];
    logic                 r_zero [0:N];
    t_cal                 r_side [0:N];

    logic signed [CW-1:0] n_re0, n_im0;
    logic [ANG_W-1:0]     n_z0;

    assign w_en[N] = !r_v[N] || i_ready;
    assign o_ready = w_en[0];

    // Fold the left half plane over by a half turn
    always_comb begin
        if (i_re < 0) begin
            n_re0 = -CW'(i_re);
            n_im0 = -CW'(i_im);
            n_z0  = ANG_HALF;
        end else begin
            n_re0 = CW'(i_re);
            n_im0 = CW'(i_im);
            n_z0  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_en[0]) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_re[0]   <= n_re0;
            r_im[0]   <= n_im0;
            r_z[0]    <= n_z0;
            r_zero[0] <= (i_im == '0) && (i_re == '0);
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_step
        logic signed [CW-1:0] w_dre, w_dim;
        logic signed [CW-1:0] n_re, n_im;
        logic [ANG_W-1:0]     n_z;

        if (k < N - 1) begin : g_chain
            assign w_en[k] = !r_v[k] || w_en[k+1];
        end else begin : g_last
            assign w_en[k] = !r_v[k] || w_en[N];
        end

        assign w_dre = r_im[k] >>> k;
        assign w_dim = r_re[k] >>> k;

        // Rotate clockwise while the imaginary part is not negative
        always_comb begin
            if (!r_im[k][CW-1]) begin
                n_re = r_re[k] + w_dre;
                n_im = r_im[k] - w_dim;
                n_z  = r_z[k] + ATAN_TAB[k];
            end else begin
                n_re = r_re[k] - w_dre;
                n_im = r_im[k] + w_dim;
                n_z  = r_z[k] - ATAN_TAB[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (w_en[k+1]) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[k+1]) begin
                r_re[k+1]   <= n_re;
                r_im[k+1]   <= n_im;
                r_z[k+1]    <= n_z;
                r_zero[k+1] <= r_zero[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_angle = r_zero[N] ? '0 : r_z[N];
    assign o_side  = r_side[N];

endmodule

// ===== design/mhsi_angle.sv =====
// ----------------------------------------------------------------------------
// mhsi_angle: binary angle to wrapped heading in centidegrees
// Stage one negates the angle and scales it by one turn in centidegrees;
// stage two rounds, adds the declination and wraps into 0..35999.
// ----------------------------------------------------------------------------
module mhsi_angle
    import mhsi_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [ANG_W-1:0]  i_angle,
    input  t_cal              i_side,
    input  logic [S_W-1:0]    i_decl,
    output logic              o_valid,
    input  logic              i_ready,
    output t_out              o_data
);

    localparam int PW = ANG_W + CD_W;
    localparam int HW = CD_W + 1;

    logic            r_va, r_vb;
    logic            w_ena, w_enb;
    logic [ANG_W-1:0] w_neg;
    logic [PW-1:0]   r_prod;
    logic [PW-1:0]   n_prod;
    t_cal            r_side;
    t_out            r_out;
    logic [PW-1:0]   w_rnd;
    logic [CD_W-1:0] w_cd;
    logic signed [HW-1:0] w_h;
    logic signed [HW-1:0] n_h;

    assign w_enb   = !r_vb || i_ready;
    assign w_ena   = !r_va || w_enb;
    assign o_ready = w_ena;

    // Negate modulo one turn before widening for the scale
    assign w_neg  = ANG_W'(0) - i_angle;
    assign n_prod = {{(PW-ANG_W){1'b0}}, w_neg} * PW'(CD_TURN);

    // Round half up, add declination, wrap once either way
    always_comb begin
        w_rnd = r_prod + PW'(ANG_HALF);
        w_cd  = w_rnd[PW-1:ANG_W];
        w_h   = $signed({1'b0, w_cd}) + HW'($signed(i_decl));
        if (w_h < 0) begin
            n_h = w_h + HW'(CD_TURN);
        end else if (w_h >= HW'(CD_TURN)) begin
            n_h = w_h - HW'(CD_TURN);
        end else begin
            n_h = w_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (w_ena) r_va <= i_valid;
            if (w_enb) r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ena) begin
            r_prod <= n_prod;
            r_side <= i_side;
        end
        if (w_enb) begin
            r_out.cal_x      <= r_side.cal_x;
            r_out.cal_y      <= r_side.cal_y;
            r_out.cal_z      <= r_side.cal_z;
            r_out.clipped    <= r_side.clipped;
            r_out.heading_cd <= n_h[S_W-1:0];
        end
    end

    assign o_valid = r_vb;
    assign o_data  = r_out;

endmodule
